// ===== hw/rtl/vorticity_jacobi_stencil_assert.svh =====
// Assertion macros used by the stencil top level.
`ifndef VORTICITY_JACOBI_STENCIL_ASSERT_SVH
`define VORTICITY_JACOBI_STENCIL_ASSERT_SVH

// Implication checked in the same cycle.
`define VJS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define VJS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/vjs_pkg.sv =====
`default_nettype none
package vjs_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 4096;

    localparam logic [12:0] ROWS_RESET = 13'd64;
    localparam logic [9:0]  COLS_RESET = 10'd64;
    localparam logic [15:0] RE_RESET   = 16'd256;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_RE   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SCALE,
        ST_DONE
    } vjs_state_t;

    typedef struct packed {
        logic clr_we;
        logic accept;
        logic load;
        logic mul;
        logic scale;
        logic done;
        logic emit;
        logic last;
    } vjs_cmd_t;

    typedef struct packed {
        logic out_busy;
    } vjs_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vjs_ctrl.sv =====
`default_nettype none
module vjs_ctrl
    import vjs_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = $clog2(MAX_ROWS + 2),
    localparam int AW = CW + 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [12:0]   rows_cfg,
    input  wire logic [9:0]    cols_cfg,
    input  vjs_status_t        status,
    output vjs_cmd_t           cmd,
    output logic [AW-1:0]      mem_addr,
    output logic [AW-1:0]      prev_addr,
    output logic [12:0]        out_row,
    output logic [9:0]         out_col
);

    vjs_state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic emit_reg, emit_next, last_reg, last_next;
    logic [12:0] orow_reg, orow_next;
    logic [9:0] ocol_reg, ocol_next;
    logic [31:0] m32, n32, r32, c32;
    logic acc;

    always_comb begin
        m32 = 32'(rows_cfg);
        if (m32 < 32'd1) m32 = 32'd1;
        if (m32 > 32'(MAX_ROWS)) m32 = 32'(MAX_ROWS);
        n32 = 32'(cols_cfg);
        if (n32 < 32'd1) n32 = 32'd1;
        if (n32 > 32'(MAX_COLS - 2)) n32 = 32'(MAX_COLS - 2);
        r32 = 32'(r_reg);
        c32 = 32'(c_reg);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc       = in_ready && in_valid;
    assign mem_addr  = (state_reg == ST_CLEAR) ? clr_reg : {r_reg[0], c_reg};
    assign prev_addr = {~r_reg[0], c_reg};
    assign out_row   = orow_reg;
    assign out_col   = ocol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            emit_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            emit_reg  <= emit_next;
            last_reg  <= last_next;
        end
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        emit_next  = emit_reg;
        last_next  = last_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        cmd        = '0;
        cmd.emit   = emit_reg;
        cmd.last   = last_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    cmd.accept = 1'b1;
                    emit_next = (r32 >= 32'd2) && (r32 <= m32 + 32'd1) &&
                                (c32 >= 32'd2) && (c32 <= n32 + 32'd1);
                    last_next = (r32 == m32 + 32'd1) && (c32 == n32 + 32'd1);
                    orow_next = 13'(r32 - 32'd1);
                    ocol_next = 10'(c32 - 32'd1);
                    // Raster advance, wrapping at the end of a row and of the grid.
                    if (c32 >= n32 + 32'd1) begin
                        c_next = '0;
                        if (r32 >= m32 + 32'd1) r_next = '0;
                        else r_next = r_reg + 1'b1;
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold while a finished word still waits at the output.
                if (!(emit_reg && status.out_busy)) begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vjs_datapath.sv =====
`default_nettype none
module vjs_datapath
    import vjs_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int AW = $clog2(MAX_COLS) + 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  vjs_cmd_t                cmd,
    input  wire logic [AW-1:0]      mem_addr,
    input  wire logic [AW-1:0]      prev_addr,
    input  wire logic signed [31:0] psi_in,
    input  wire logic signed [31:0] zeta_in,
    input  wire logic [15:0]        reynolds,
    input  wire logic [12:0]        row_in,
    input  wire logic [9:0]         col_in,
    output vjs_status_t             status,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      psi_new,
    output logic signed [31:0]      zeta_new,
    output logic [12:0]             out_row,
    output logic [9:0]              out_col,
    output logic                    out_last
);

    logic [31:0] psi_mem [2**AW];
    logic [31:0] zeta_mem [2**AW];
    logic signed [31:0] pcur_reg, pprev_reg, zcur_reg, zprev_reg;
    logic signed [31:0] pin_reg, zin_reg;
    logic signed [31:0] pw_reg [9];
    logic signed [31:0] zw_reg [9];
    logic signed [49:0] prod1_reg, prod2_reg;
    logic signed [34:0] psum_reg;
    logic signed [33:0] zsum_reg;
    logic signed [64:0] term_reg;
    logic               ov_reg;
    logic signed [31:0] opsi_reg, ozeta_reg;
    logic [12:0]        orow_reg;
    logic [9:0]         ocol_reg;
    logic               olast_reg;

    logic signed [32:0] dpx, dzy, dpy, dzx;
    logic signed [65:0] p1, p2;
    logic signed [50:0] jac;
    logic signed [47:0] jac_c;
    logic signed [63:0] zpre, ppre;

    // Line stores: read-before-write on the current slot gives the older row.
    always_ff @(posedge aclk) begin
        if (cmd.clr_we) begin
            psi_mem[mem_addr]  <= '0;
            zeta_mem[mem_addr] <= '0;
        end else if (cmd.accept) begin
            psi_mem[mem_addr]  <= psi_in;
            zeta_mem[mem_addr] <= zeta_in;
        end
        pcur_reg  <= psi_mem[mem_addr];
        zcur_reg  <= zeta_mem[mem_addr];
        pprev_reg <= psi_mem[prev_addr];
        zprev_reg <= zeta_mem[prev_addr];
    end

    always_comb begin
        dpx = 33'(pw_reg[5]) - 33'(pw_reg[3]);
        dzy = 33'(zw_reg[7]) - 33'(zw_reg[1]);
        dpy = 33'(pw_reg[7]) - 33'(pw_reg[1]);
        dzx = 33'(zw_reg[5]) - 33'(zw_reg[3]);
        p1  = dpx * dzy;
        p2  = dpy * dzx;
        jac = 51'(prod1_reg) - 51'(prod2_reg);
        if (jac > 51'sd140737488355327) begin
            jac_c = 48'sh7fffffffffff;
        end else if (jac < -51'sd140737488355328) begin
            jac_c = 48'sh800000000000;
        end else begin
            jac_c = jac[47:0];
        end
        ppre = 64'(psum_reg >>> 2);
        zpre = 64'(zsum_reg >>> 2) - 64'(term_reg >>> 12);
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pin_reg <= psi_in;
            zin_reg <= zeta_in;
        end
        if (cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                pw_reg[k*3]   <= pw_reg[k*3+1];
                pw_reg[k*3+1] <= pw_reg[k*3+2];
                zw_reg[k*3]   <= zw_reg[k*3+1];
                zw_reg[k*3+1] <= zw_reg[k*3+2];
            end
            pw_reg[2] <= pcur_reg;
            pw_reg[5] <= pprev_reg;
            pw_reg[8] <= pin_reg;
            zw_reg[2] <= zcur_reg;
            zw_reg[5] <= zprev_reg;
            zw_reg[8] <= zin_reg;
        end
        if (cmd.mul) begin
            prod1_reg <= 50'(p1 >>> 16);
            prod2_reg <= 50'(p2 >>> 16);
            psum_reg  <= 35'(pw_reg[1]) + 35'(pw_reg[7]) + 35'(pw_reg[3])
                       + 35'(pw_reg[5]) - 35'(zw_reg[4]);
            zsum_reg  <= 34'(zw_reg[1]) + 34'(zw_reg[7]) + 34'(zw_reg[3])
                       + 34'(zw_reg[5]);
        end
        if (cmd.scale) begin
            term_reg <= 65'(jac_c) * $signed({1'b0, reynolds});
        end
        if (cmd.done && cmd.emit) begin
            opsi_reg  <= sat32(ppre);
            ozeta_reg <= sat32(zpre);
            orow_reg  <= row_in;
            ocol_reg  <= col_in;
            olast_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.done && cmd.emit) begin
            ov_reg <= 1'b1;
        end else if (out_ready) begin
            ov_reg <= 1'b0;
        end
    end

    assign status.out_busy = ov_reg && !out_ready;
    assign out_valid = ov_reg;
    assign psi_new   = opsi_reg;
    assign zeta_new  = ozeta_reg;
    assign out_row   = orow_reg;
    assign out_col   = ocol_reg;
    assign out_last  = olast_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vorticity_jacobi_stencil.sv =====
// Flow: a word is accepted only while the controller is idle; each word then runs the
// controller sequence of line-store read, window shift, cross-product multiply, Reynolds
// scale and output, and the output step waits while an earlier result is still held.
// Reset (aresetn low, synchronous) clears control state, then a clearing pass over
// every line-store slot zeroes the line stores; no input word is taken during it.
`default_nettype none
module vorticity_jacobi_stencil
    import vjs_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // psi_in, zeta_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // psi_new, zeta_new, out_row, out_col, zero pad
    output logic             m_tlast,   // last_of_grid
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(MAX_COLS) + 1;

    logic [12:0] rows_reg;
    logic [9:0]  cols_reg;
    logic [15:0] re_reg;
    vjs_cmd_t    cmd;
    vjs_status_t status;
    logic [AW-1:0] mem_addr, prev_addr;
    logic [12:0] row_w, orow;
    logic [9:0]  col_w, ocol;
    logic signed [31:0] opsi, ozeta;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            re_reg   <= RE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_ROWS: rows_reg <= pwdata[12:0];
                REG_COLS: cols_reg <= pwdata[9:0];
                REG_RE:   re_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS: prdata = 32'(rows_reg);
            REG_COLS: prdata = 32'(cols_reg);
            REG_RE:   prdata = 32'(re_reg);
            default:  prdata = '0;
        endcase
    end

    vjs_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .rows_cfg(rows_reg), .cols_cfg(cols_reg),
        .status(status), .cmd(cmd),
        .mem_addr(mem_addr), .prev_addr(prev_addr),
        .out_row(row_w), .out_col(col_w)
    );

    vjs_datapath #(.MAX_COLS(MAX_COLS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .mem_addr(mem_addr), .prev_addr(prev_addr),
        .psi_in(s_tdata[31:0]), .zeta_in(s_tdata[63:32]),
        .reynolds(re_reg), .row_in(row_w), .col_in(col_w),
        .status(status), .out_valid(m_tvalid), .out_ready(m_tready),
        .psi_new(opsi), .zeta_new(ozeta), .out_row(orow), .out_col(ocol),
        .out_last(m_tlast)
    );

    assign m_tdata = {1'b0, ocol, orow, ozeta, opsi};

`include "vorticity_jacobi_stencil_assert.svh"

    // Only one word is in flight: an accepted word closes the input side.
    `VJS_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // Emitted points never lie on halo row zero or halo column zero.
    `VJS_ASSERT_IMP(a_interior_only, aclk, aresetn, m_tvalid,
        (m_tdata[76:64] != 13'd0) && (m_tdata[86:77] != 10'd0))

endmodule
`default_nettype wire

// ===== dv/tb_vorticity_jacobi_stencil.sv =====
`default_nettype none
module tb_vorticity_jacobi_stencil;
    import vjs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS = DEF_MAX_COLS;
    localparam int NROWS = DEF_MAX_ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam logic [3:0] ADDR_JUNK = 4'd12;

    typedef struct {
        logic [31:0] psi;
        logic [31:0] zeta;
        logic [12:0] row;
        logic [9:0]  col;
        logic        last;
    } stencil_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // psi_in, zeta_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;        // psi_new, zeta_new, out_row, out_col, zero pad
    logic        m_tlast;        // last_of_grid
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    vorticity_jacobi_stencil u_dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Shadow copy of the stencil state.
    logic [31:0] psi_rows [2*NCOLS];
    logic [31:0] zeta_rows [2*NCOLS];
    logic [31:0] win [18];
    int unsigned pos_r, pos_c;
    logic [12:0] cfg_rows;
    logic [9:0]  cfg_cols;
    logic [15:0] cfg_re;

    stencil_out_t pending_q [$];
    int  n_errors = 0;
    bit  no_idle = 0;
    int  quiet_cycles = 0;

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint prod_q16(longint a, longint b);
        bit neg;
        logic [63:0] ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p = ma * mb;
        if (!neg) return longint'(p >> 16);
        return -longint'((p + 64'hFFFF) >> 16);
    endfunction

    function automatic logic [31:0] clip_q16(longint x);
        if (x > 64'sd2147483647) return 32'h7fffffff;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[31:0];
    endfunction

    task automatic predict_stencil(logic [31:0] psi_in, logic [31:0] zeta_in);
        int unsigned m, n, col, cur, prv;
        longint pu, pd, pl, pr, zu, zd, zl, zr, zc, jac, term;
        stencil_out_t e;
        m = (cfg_rows < 1) ? 1 : (cfg_rows > NROWS) ? NROWS : cfg_rows;
        n = (cfg_cols < 1) ? 1 : (cfg_cols > NCOLS - 2) ? NCOLS - 2 : cfg_cols;
        col = (pos_c < NCOLS) ? pos_c : NCOLS - 1;
        cur = (pos_r & 1) * NCOLS + col;
        prv = ((pos_r + 1) & 1) * NCOLS + col;
        for (int f = 0; f < 2; f++) begin
            for (int k = 0; k < 3; k++) begin
                win[f*9+k*3]   = win[f*9+k*3+1];
                win[f*9+k*3+1] = win[f*9+k*3+2];
            end
        end
        win[2] = psi_rows[cur];   win[5] = psi_rows[prv];   win[8] = psi_in;
        win[11] = zeta_rows[cur]; win[14] = zeta_rows[prv]; win[17] = zeta_in;
        psi_rows[cur] = psi_in;
        zeta_rows[cur] = zeta_in;
        if (pos_r >= 2 && pos_r <= m + 1 && pos_c >= 2 && pos_c <= n + 1) begin
            pu = sx(win[1]);  pd = sx(win[7]);  pl = sx(win[3]);  pr = sx(win[5]);
            zu = sx(win[10]); zd = sx(win[16]); zl = sx(win[12]); zr = sx(win[14]);
            zc = sx(win[13]);
            jac = prod_q16(pr - pl, zd - zu) - prod_q16(pd - pu, zr - zl);
            if (jac > (64'sd1 <<< 47) - 1) jac = (64'sd1 <<< 47) - 1;
            if (jac < -(64'sd1 <<< 47)) jac = -(64'sd1 <<< 47);
            term = (jac * longint'(cfg_re)) >>> 12;
            e.psi  = clip_q16((pu + pd + pl + pr - zc) >>> 2);
            e.zeta = clip_q16(((zu + zd + zl + zr) >>> 2) - term);
            e.row  = 13'(pos_r - 1);
            e.col  = 10'(pos_c - 1);
            e.last = (pos_r == m + 1 && pos_c == n + 1);
            pending_q.push_back(e);
        end
        pos_c++;
        if (pos_c >= n + 2) begin
            pos_c = 0;
            pos_r++;
            if (pos_r >= m + 2) pos_r = 0;
        end
    endtask

    // Result checker: compares every accepted word with the oldest prediction.
    always @(posedge aclk) begin
        stencil_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                n_errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_tdata[31:0] !== e.psi) begin
                    $error("psi_new exp %h got %h", e.psi, m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tdata[63:32] !== e.zeta) begin
                    $error("zeta_new exp %h got %h", e.zeta, m_tdata[63:32]);
                    n_errors++;
                end
                if (m_tdata[76:64] !== e.row) begin
                    $error("out_row exp %0d got %0d", e.row, m_tdata[76:64]);
                    n_errors++;
                end
                if (m_tdata[86:77] !== e.col) begin
                    $error("out_col exp %0d got %0d", e.col, m_tdata[86:77]);
                    n_errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_of_grid exp %0d got %0d", e.last, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver with random back-pressure.
    initial begin
        int k;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            k = no_idle ? 0 : $urandom_range(0, 5);
            if (k > 0) begin
                m_tready <= 1'b0;
                repeat (k) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(logic [31:0] psi_in, logic [31:0] zeta_in);
        int k;
        @(negedge aclk);
        k = no_idle ? 0 : $urandom_range(0, 5);
        if (k > 0) begin
            s_tvalid <= 1'b0;
            repeat (k) @(negedge aclk);
        end
        s_tdata  <= {zeta_in, psi_in};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_stencil(psi_in, zeta_in);
    endtask

    task automatic pause_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Drain all results, then let any in-flight word without a result settle.
    task automatic wait_drained();
        pause_sender();
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [31:0] data);
        wait_drained();
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (addr)
            {REG_ROWS, 2'b00}: cfg_rows = data[12:0];
            {REG_COLS, 2'b00}: cfg_cols = data[9:0];
            {REG_RE, 2'b00}:   cfg_re = data[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_grid(int rows, int cols, int re);
        write_reg({REG_ROWS, 2'b00}, rows);
        write_reg({REG_COLS, 2'b00}, cols);
        write_reg({REG_RE, 2'b00}, re);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2, 3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_points(int count);
        repeat (count) send_word(rand_q16(), rand_q16());
    endtask

    task automatic test_extremes();
        logic [31:0] vals [4] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
        set_grid(1, 1, 0);
        for (int i = 0; i < 9; i++) send_word(vals[i % 4], vals[(i + 1) % 4]);
        set_grid(2, 1, 16'hffff);
        for (int i = 0; i < 12; i++) send_word(vals[(i * 3) % 4], vals[(i >> 1) % 4]);
    endtask

    task automatic test_register_bounds();
        // Zero sizes clamp to one; a write past the register list is dropped.
        set_grid(0, 0, 1);
        write_reg(ADDR_JUNK, 32'hffffffff);
        send_points(9);
        // Oversized sizes clamp; then shrink the grid partway through a row.
        set_grid(8191, 1023, 256);
        send_points(1024 + 5);
        set_grid(2, 2, 300);
        send_points(40);
    endtask

    task automatic test_random_grids(int budget);
        int m, n, sent;
        sent = 0;
        while (sent < budget) begin
            set_grid($urandom_range(1, 6), $urandom_range(1, 8),
                     $urandom_range(0, 3) == 0 ? 16'hffff : $urandom_range(0, 65535));
            no_idle = ($urandom_range(0, 7) == 0);
            m = (cfg_rows < 1) ? 1 : cfg_rows;
            n = (cfg_cols < 1) ? 1 : cfg_cols;
            send_points((m + 2) * (n + 2));
            sent += (m + 2) * (n + 2);
            no_idle = 0;
        end
    endtask

    initial begin
        foreach (psi_rows[i]) begin
            psi_rows[i] = '0;
            zeta_rows[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        pos_r = 0; pos_c = 0;
        cfg_rows = ROWS_RESET; cfg_cols = COLS_RESET; cfg_re = RE_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_register_bounds();
        test_random_grids(550);
        test_random_grids(250);
        wait_drained();
        repeat (10) @(posedge aclk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vjs_pkg.sv
hw/rtl/vjs_ctrl.sv
hw/rtl/vjs_datapath.sv
hw/rtl/vorticity_jacobi_stencil.sv
dv/tb_vorticity_jacobi_stencil.sv
